// ===== src/entity_tag_list_parser_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Entity-tag list parser assertion macros
// Shared concurrent assertion shorthands for the parser modules.
// ----------------------------------------------------------------------------
`ifndef ENTITY_TAG_LIST_PARSER_UNIT_MACROS_SVH
`define ENTITY_TAG_LIST_PARSER_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ETLP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("etlp assertion failed");

// next-cycle implication, disabled while reset is asserted
`define ETLP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("etlp assertion failed");

`endif

// ===== src/etlp_pkg.sv =====
// ----------------------------------------------------------------------------
// Entity-tag list parser package
// Shared types, character constants and the recognizer transition function.
// ----------------------------------------------------------------------------
package etlp_pkg;

  // queue between classifier and recognizer
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // character codes
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_W     = 8'h57;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_TAG_LO = 8'h21;
  localparam logic [7:0] CH_TAG_HI = 8'h7e;

  typedef enum logic [3:0] {
    ST_DEAD           = 4'd0,
    ST_START          = 4'd1,
    ST_AFTER_COMMA    = 4'd2,
    ST_AFTER_W        = 4'd3,
    ST_AFTER_SLASH    = 4'd4,
    ST_IN_QUOTE       = 4'd5,
    ST_AFTER_TAG      = 4'd6,
    ST_AFTER_TAG_COMMA = 4'd7,
    ST_AFTER_STAR     = 4'd8
  } state_e;

  typedef enum logic [3:0] {
    CL_BAD   = 4'd0,
    CL_SPACE = 4'd1,
    CL_COMMA = 4'd2,
    CL_STAR  = 4'd3,
    CL_QUOTE = 4'd4,
    CL_W     = 4'd5,
    CL_SLASH = 4'd6,
    CL_TAGCH = 4'd7,
    CL_END   = 4'd8
  } cls_e;

  // state-independent view of one input word
  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_marker;
    cls_e       base_cls;   // class as seen outside quotes
    logic       printable;  // 0x21..0x7e, not end
  } word_info_t;

  typedef struct packed {
    state_e nxt_state;
    logic   live;    // transition exists
    logic   match;   // end accepted
  } step_t;

  typedef struct packed {
    logic [7:0] tag_byte;
    logic       in_tag;
    logic       tag_complete;
    logic       field_end;
    logic       field_accepted;
    logic       rejected;
  } result_t;

  function automatic step_t step_fn(input state_e st, input cls_e cl);
    step_t r;
    r.nxt_state = ST_DEAD;
    r.live      = 1'b1;
    r.match     = 1'b0;
    case (st)
      ST_START: begin
        case (cl)
          CL_SPACE: r.nxt_state = ST_START;
          CL_COMMA: r.nxt_state = ST_AFTER_COMMA;
          CL_STAR:  r.nxt_state = ST_AFTER_STAR;
          CL_QUOTE: r.nxt_state = ST_IN_QUOTE;
          CL_W:     r.nxt_state = ST_AFTER_W;
          default:  r.live = 1'b0;
        endcase
      end
      ST_AFTER_COMMA: begin
        case (cl)
          CL_SPACE, CL_COMMA: r.nxt_state = ST_AFTER_COMMA;
          CL_QUOTE: r.nxt_state = ST_IN_QUOTE;
          CL_W:     r.nxt_state = ST_AFTER_W;
          default:  r.live = 1'b0;
        endcase
      end
      ST_AFTER_W: begin
        case (cl)
          CL_SLASH: r.nxt_state = ST_AFTER_SLASH;
          default:  r.live = 1'b0;
        endcase
      end
      ST_AFTER_SLASH: begin
        case (cl)
          CL_QUOTE: r.nxt_state = ST_IN_QUOTE;
          default:  r.live = 1'b0;
        endcase
      end
      ST_IN_QUOTE: begin
        case (cl)
          CL_QUOTE: r.nxt_state = ST_AFTER_TAG;
          CL_TAGCH: r.nxt_state = ST_IN_QUOTE;
          default:  r.live = 1'b0;
        endcase
      end
      ST_AFTER_TAG: begin
        case (cl)
          CL_SPACE: r.nxt_state = ST_AFTER_TAG;
          CL_COMMA: r.nxt_state = ST_AFTER_TAG_COMMA;
          CL_END: begin
            r.nxt_state = ST_START;
            r.match     = 1'b1;
          end
          default:  r.live = 1'b0;
        endcase
      end
      ST_AFTER_TAG_COMMA: begin
        case (cl)
          CL_SPACE, CL_COMMA: r.nxt_state = ST_AFTER_TAG_COMMA;
          CL_QUOTE: r.nxt_state = ST_IN_QUOTE;
          CL_W:     r.nxt_state = ST_AFTER_W;
          CL_END: begin
            r.nxt_state = ST_START;
            r.match     = 1'b1;
          end
          default:  r.live = 1'b0;
        endcase
      end
      ST_AFTER_STAR: begin
        case (cl)
          CL_SPACE: r.nxt_state = ST_AFTER_STAR;
          CL_END: begin
            r.nxt_state = ST_START;
            r.match     = 1'b1;
          end
          default:  r.live = 1'b0;
        endcase
      end
      default: r.live = 1'b0;  // dead
    endcase
    return r;
  endfunction

endpackage

// ===== src/etlp_if.sv =====
// ----------------------------------------------------------------------------
// Entity-tag list parser channel interfaces
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface etlp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_marker;

  modport source (output valid, output text_byte, output end_marker, input ready);
  modport sink   (input valid, input text_byte, input end_marker, output ready);
endinterface

interface etlp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] tag_byte;
  logic       in_tag;
  logic       tag_complete;
  logic       field_end;
  logic       field_accepted;
  logic       rejected;

  modport source (output valid, output tag_byte, output in_tag, output tag_complete,
                  output field_end, output field_accepted, output rejected,
                  input ready);
  modport sink   (input valid, input tag_byte, input in_tag, input tag_complete,
                  input field_end, input field_accepted, input rejected,
                  output ready);
endinterface

// ===== src/etlp_front.sv =====
// ----------------------------------------------------------------------------
// Entity-tag list parser front end
// Accepts input words and classes each byte independently of parser state.
// ----------------------------------------------------------------------------
module etlp_front (
  etlp_in_if.sink              in_i,
  output logic                 push_valid_o,
  input  logic                 push_ready_i,
  output etlp_pkg::word_info_t push_data_o
);

  etlp_pkg::cls_e base_cls;

  always_comb begin
    if (in_i.end_marker) begin
      base_cls = etlp_pkg::CL_END;
    end else begin
      case (in_i.text_byte)
        etlp_pkg::CH_TAB, etlp_pkg::CH_SPACE: base_cls = etlp_pkg::CL_SPACE;
        etlp_pkg::CH_QUOTE: base_cls = etlp_pkg::CL_QUOTE;
        etlp_pkg::CH_COMMA: base_cls = etlp_pkg::CL_COMMA;
        etlp_pkg::CH_STAR:  base_cls = etlp_pkg::CL_STAR;
        etlp_pkg::CH_W:     base_cls = etlp_pkg::CL_W;
        etlp_pkg::CH_SLASH: base_cls = etlp_pkg::CL_SLASH;
        default:            base_cls = etlp_pkg::CL_BAD;
      endcase
    end
  end

  always_comb begin
    push_data_o.text_byte  = in_i.text_byte;
    push_data_o.end_marker = in_i.end_marker;
    push_data_o.base_cls   = base_cls;
    push_data_o.printable  = !in_i.end_marker &&
        (in_i.text_byte inside {[etlp_pkg::CH_TAG_LO:etlp_pkg::CH_TAG_HI]});
  end

  assign push_valid_o = in_i.valid;
  assign in_i.ready   = push_ready_i;

endmodule

// ===== src/etlp_queue.sv =====
// ----------------------------------------------------------------------------
// Entity-tag list parser word queue
// Short FIFO decoupling the classifier from the recognizer.
// ----------------------------------------------------------------------------
`include "entity_tag_list_parser_unit_macros.svh"

module etlp_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_valid_i,
  output logic                 push_ready_o,
  input  etlp_pkg::word_info_t push_data_i,
  output logic                 pop_valid_o,
  input  logic                 pop_ready_i,
  output etlp_pkg::word_info_t pop_data_o
);

  localparam logic [etlp_pkg::QPTR_W-1:0] PtrLast = etlp_pkg::QPTR_W'(etlp_pkg::QUEUE_DEPTH - 1);
  localparam logic [etlp_pkg::QCNT_W-1:0] CntFull = etlp_pkg::QCNT_W'(etlp_pkg::QUEUE_DEPTH);

  etlp_pkg::word_info_t            mem_q [etlp_pkg::QUEUE_DEPTH];
  logic [etlp_pkg::QPTR_W-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [etlp_pkg::QCNT_W-1:0]     count_q, count_d;
  logic                            push_fire, pop_fire;

  assign push_ready_o = (count_q != CntFull);
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push_fire    = push_valid_i && push_ready_o;
  assign pop_fire     = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_fire) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_fire) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_fire && !pop_fire) begin
      count_d = count_q + 1'b1;
    end else if (pop_fire && !push_fire) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_fire) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `ETLP_ASSERT_IMPLY(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CntFull)
  `ETLP_ASSERT_NEXT(a_push_only_grows, clk_i, rst_ni, push_fire && !pop_fire, count_q == $past(count_q) + 1'b1)
  `ETLP_ASSERT_NEXT(a_pop_only_shrinks, clk_i, rst_ni, pop_fire && !push_fire, count_q == $past(count_q) - 1'b1)

endmodule

// ===== src/etlp_back.sv =====
// ----------------------------------------------------------------------------
// Entity-tag list parser recognizer
// Resolves quote-dependent class, steps the state table, registers the result.
// ----------------------------------------------------------------------------
`include "entity_tag_list_parser_unit_macros.svh"

module etlp_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 pop_valid_i,
  output logic                 pop_ready_o,
  input  etlp_pkg::word_info_t pop_data_i,
  etlp_out_if.source           out_o
);

  etlp_pkg::state_e  state_q, state_d;
  etlp_pkg::cls_e    cls;
  etlp_pkg::step_t   step;
  etlp_pkg::result_t res, res_q;
  logic              out_valid_q, out_valid_d;
  logic              fire;

  assign pop_ready_o = !out_valid_q || out_o.ready;
  assign fire        = pop_valid_i && pop_ready_o;

  // inside quotes any printable except the quote itself is a tag character
  always_comb begin
    cls = pop_data_i.base_cls;
    if (state_q == etlp_pkg::ST_IN_QUOTE && pop_data_i.printable &&
        pop_data_i.base_cls != etlp_pkg::CL_QUOTE) begin
      cls = etlp_pkg::CL_TAGCH;
    end
  end

  assign step = etlp_pkg::step_fn(state_q, cls);

  always_comb begin
    res.in_tag = step.live && (cls inside {etlp_pkg::CL_STAR, etlp_pkg::CL_QUOTE,
        etlp_pkg::CL_W, etlp_pkg::CL_SLASH, etlp_pkg::CL_TAGCH});
    res.tag_byte = res.in_tag ? pop_data_i.text_byte : 8'h00;
    res.tag_complete = step.live &&
        (state_q inside {etlp_pkg::ST_AFTER_TAG, etlp_pkg::ST_AFTER_STAR}) &&
        (cls inside {etlp_pkg::CL_COMMA, etlp_pkg::CL_END});
    res.field_end      = pop_data_i.end_marker;
    res.field_accepted = pop_data_i.end_marker && step.match;
    res.rejected       = pop_data_i.end_marker ? !step.match : !step.live;
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
      if (pop_data_i.end_marker) begin
        state_d = etlp_pkg::ST_START;
      end else if (step.live) begin
        state_d = step.nxt_state;
      end else begin
        state_d = etlp_pkg::ST_DEAD;
      end
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= etlp_pkg::ST_START;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.tag_byte       = res_q.tag_byte;
  assign out_o.in_tag         = res_q.in_tag;
  assign out_o.tag_complete   = res_q.tag_complete;
  assign out_o.field_end      = res_q.field_end;
  assign out_o.field_accepted = res_q.field_accepted;
  assign out_o.rejected       = res_q.rejected;

  `ETLP_ASSERT_NEXT(a_end_restarts, clk_i, rst_ni, fire && pop_data_i.end_marker, state_q == etlp_pkg::ST_START)
  `ETLP_ASSERT_IMPLY(a_end_verdict, clk_i, rst_ni, out_valid_q && res_q.field_end, res_q.field_accepted != res_q.rejected)
  `ETLP_ASSERT_IMPLY(a_accept_on_end, clk_i, rst_ni, out_valid_q && res_q.field_accepted, res_q.field_end)
  `ETLP_ASSERT_NEXT(a_stall_holds, clk_i, rst_ni, out_valid_q && !out_o.ready, out_valid_q && $stable(res_q))

endmodule

// ===== src/entity_tag_list_parser_unit.sv =====
// ----------------------------------------------------------------------------
// Entity-tag list parser unit
// Streaming recognizer for an HTTP entity-tag list header field.
// ----------------------------------------------------------------------------
// Feed the field one byte per word on in_i, then one word with end_marker set;
// every word gives exactly one result word on out_o. While the output is not
// stalled, the unit sustains one word per clock in both directions. An input
// word is registered into the two-word queue, then the recognizer step into
// the output register, which drives out_o. The rate is set by the state
// register loop in the recognizer: class resolution plus one table step.
// Either side may stall on its own: the queue absorbs input while the output
// is held, and the output register keeps a result until it is taken.
// in_tag marks bytes that form tag text (quote, W, slash, star, tag
// characters); tag_byte echoes them and is zero otherwise. tag_complete
// flags the comma or end marker that closes a tag or star. A bad byte sets
// rejected and the parser stays dead until the end marker, whose result
// carries field_end and the field_accepted verdict; parsing then restarts.
// ----------------------------------------------------------------------------
module entity_tag_list_parser_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  etlp_in_if.sink    in_i,
  etlp_out_if.source out_o
);

  // classifier -> queue
  logic                 push_valid, push_ready;
  etlp_pkg::word_info_t push_data;
  // queue -> recognizer
  logic                 pop_valid, pop_ready;
  etlp_pkg::word_info_t pop_data;

  // front: byte classes that do not depend on parser state
  etlp_front u_front (
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // short queue lets input keep flowing while the output stalls
  etlp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // back: quote-aware class, state step, registered result
  etlp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_o       (out_o)
  );

endmodule
